// File: rtl/yrgb_pkg.sv
// Shared types and constants of the YUYV to RGB888 converter.
// Used by the front, queue, back and top-level modules; depends on nothing.
package yrgb_pkg;

	localparam int LP_W      = 12;	// line_pairs register width
	localparam int FR_W      = 13;	// frame_rows register width
	localparam int ADDR_W    = 23;	// pair address width
	localparam int FRAC_BITS = 14;
	localparam int ACC_W     = 25;	// signed Q.14 channel accumulator

	localparam logic [LP_W-1:0] LINE_PAIRS_RST = 12'd320;
	localparam logic [FR_W-1:0] FRAME_ROWS_RST = 13'd480;

	// Q2.14 coefficients, rounded to nearest
	localparam logic signed [15:0] COEF_RV = 16'sd22970;	// 1.402
	localparam logic signed [15:0] COEF_GU = 16'sd5638;	// 0.34414
	localparam logic signed [15:0] COEF_GV = 16'sd11700;	// 0.71414
	localparam logic signed [15:0] COEF_BU = 16'sd29032;	// 1.772
	localparam logic signed [8:0]  CHROMA_OFS = 9'sd128;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	typedef enum logic [0:0] {
		REG_LINE_PAIRS = 1'b0,
		REG_FRAME_ROWS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [LP_W-1:0] line_pairs;
		logic [FR_W-1:0] frame_rows;
		logic            restart;
	} cfg_t;

	typedef struct packed {
		logic [7:0]        y0;
		logic [7:0]        u;
		logic [7:0]        y1;
		logic [7:0]        v;
		logic [ADDR_W-1:0] addr;
		logic              last;
	} pix_entry_t;

	typedef struct packed {
		logic [7:0]        b0;
		logic [7:0]        g0;
		logic [7:0]        r0;
		logic [7:0]        b1;
		logic [7:0]        g1;
		logic [7:0]        r1;
		logic [ADDR_W-1:0] addr;
		logic              last;
	} rgb_t;

endpackage

// File: rtl/yuyv_to_rgb888_bottom_up.sv
// Top level of the YUYV 4:2:2 to RGB888 converter with bottom-up addressing.
// Depends on yrgb_pkg, yrgb_front, yrgb_queue and yrgb_back.
//
// Usage:
//   Input transaction (pix_valid/pix_ready): one YUYV macropixel per cycle
//   while pix_ready is high, in raster order. Output transaction
//   (rgb_valid/rgb_ready): B,G,R of both pixels, the pair address in a frame
//   stored bottom line first, and last_in_frame on the final pair of the frame.
//   Throughput is one macropixel per cycle while the receiver keeps up. From
//   input acceptance to rgb_valid, a macropixel passes through the four-entry
//   queue, the product stage, then the sum/clamp output register.
//   The front end computes addresses as pairs arrive; the base address of a
//   frame, (frame_rows-1)*line_pairs, is formed by one multiplier when the
//   first pair of a frame comes in.
//   When the receiver stalls, the output register holds its transaction and
//   the queue keeps absorbing input; pix_ready drops only when it fills.
//   Reset clears counters and pipeline valids and loads line_pairs = 320 and
//   frame_rows = 480. The APB registers sit at 0x0 (line_pairs) and 0x4
//   (frame_rows); a write to either restarts the frame at the top line.
//   Write registers only while the block is idle.
module yuyv_to_rgb888_bottom_up #(
	parameter int MAX_LINE_PAIRS = 2048,
	parameter int MAX_ROWS       = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// macropixel input
	input  logic                         pix_valid,
	output logic                         pix_ready,
	input  logic [7:0]                   luma_first,
	input  logic [7:0]                   chroma_blue,
	input  logic [7:0]                   luma_second,
	input  logic [7:0]                   chroma_red,
	// pixel pair output
	output logic                         rgb_valid,
	input  logic                         rgb_ready,
	output logic [7:0]                   blue_first,
	output logic [7:0]                   green_first,
	output logic [7:0]                   red_first,
	output logic [7:0]                   blue_second,
	output logic [7:0]                   green_second,
	output logic [7:0]                   red_second,
	output logic [yrgb_pkg::ADDR_W-1:0]  pair_address,
	output logic                         last_in_frame
);

	logic [yrgb_pkg::LP_W-1:0] line_pairs_q;
	logic [yrgb_pkg::FR_W-1:0] frame_rows_q;
	logic                      cfg_wr;
	yrgb_pkg::reg_idx_t        reg_idx;
	yrgb_pkg::cfg_t            cfg;
	yrgb_pkg::pix_entry_t      q_wdata, q_rdata;
	yrgb_pkg::rgb_t            rgb;
	logic                      q_push, q_pop, q_full, q_valid;

	// register file: the write lands in the access phase
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = yrgb_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pairs_q <= yrgb_pkg::LINE_PAIRS_RST;
			frame_rows_q <= yrgb_pkg::FRAME_ROWS_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				yrgb_pkg::REG_LINE_PAIRS: line_pairs_q <= pwdata[yrgb_pkg::LP_W-1:0];
				yrgb_pkg::REG_FRAME_ROWS: frame_rows_q <= pwdata[yrgb_pkg::FR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			yrgb_pkg::REG_LINE_PAIRS: prdata = 32'(line_pairs_q);
			yrgb_pkg::REG_FRAME_ROWS: prdata = 32'(frame_rows_q);
			default:                  prdata = '0;
		endcase
	end

	// any register write restarts the frame
	assign cfg.line_pairs = line_pairs_q;
	assign cfg.frame_rows = frame_rows_q;
	assign cfg.restart    = cfg_wr;

	yrgb_front #(
		.MAX_LINE_PAIRS (MAX_LINE_PAIRS),
		.MAX_ROWS       (MAX_ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.luma_first  (luma_first),
		.chroma_blue (chroma_blue),
		.luma_second (luma_second),
		.chroma_red  (chroma_red),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_wdata     (q_wdata)
	);

	yrgb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	yrgb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (rgb_valid),
		.out_ready (rgb_ready),
		.out_data  (rgb)
	);

	assign blue_first    = rgb.b0;
	assign green_first   = rgb.g0;
	assign red_first     = rgb.r0;
	assign blue_second   = rgb.b1;
	assign green_second  = rgb.g1;
	assign red_second    = rgb.r1;
	assign pair_address  = rgb.addr;
	assign last_in_frame = rgb.last;

endmodule

// File: rtl/yrgb_front.sv
// Front end: accepts macropixels, tracks column/row and computes the
// bottom-up pair address and end-of-frame flag. Depends on yrgb_pkg.
module yrgb_front #(
	parameter int MAX_LINE_PAIRS = 2048,
	parameter int MAX_ROWS       = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  yrgb_pkg::cfg_t       cfg,
	input  logic                 pix_valid,
	output logic                 pix_ready,
	input  logic [7:0]           luma_first,
	input  logic [7:0]           chroma_blue,
	input  logic [7:0]           luma_second,
	input  logic [7:0]           chroma_red,
	input  logic                 q_full,
	output logic                 q_push,
	output yrgb_pkg::pix_entry_t q_wdata
);

	localparam int PW  = $clog2(MAX_LINE_PAIRS + 1);
	localparam int CW  = (MAX_LINE_PAIRS > 1) ? $clog2(MAX_LINE_PAIRS) : 1;
	localparam int RPW = $clog2(MAX_ROWS + 1);
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int MW  = PW + RPW;
	localparam int AW  = yrgb_pkg::ADDR_W;

	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [AW-1:0]  row_base_q;
	logic [PW-1:0]  pairs_c;
	logic [RPW-1:0] rows_c;
	logic [MW-1:0]  prod_full;
	logic [AW-1:0]  base;
	logic           end_line;
	logic           end_frame;

	// clamp the registers to the legal ranges; zero acts as one
	always_comb begin
		if (cfg.line_pairs == '0) begin
			pairs_c = PW'(1);
		end else if (13'(cfg.line_pairs) > 13'(MAX_LINE_PAIRS)) begin
			pairs_c = PW'(MAX_LINE_PAIRS);
		end else begin
			pairs_c = PW'(cfg.line_pairs);
		end
		if (cfg.frame_rows == '0) begin
			rows_c = RPW'(1);
		end else if (14'(cfg.frame_rows) > 14'(MAX_ROWS)) begin
			rows_c = RPW'(MAX_ROWS);
		end else begin
			rows_c = RPW'(cfg.frame_rows);
		end
	end

	assign prod_full = MW'(rows_c - RPW'(1)) * MW'(pairs_c);
	assign base      = (col_q == '0 && row_q == '0) ? AW'(prod_full) : row_base_q;
	assign end_line  = (PW'(col_q) + PW'(1)) >= pairs_c;
	assign end_frame = end_line && ((RPW'(row_q) + RPW'(1)) >= rows_c);

	assign pix_ready     = !q_full;
	assign q_push        = pix_valid && !q_full;
	assign q_wdata.y0    = luma_first;
	assign q_wdata.u     = chroma_blue;
	assign q_wdata.y1    = luma_second;
	assign q_wdata.v     = chroma_red;
	assign q_wdata.addr  = base + AW'(col_q);
	assign q_wdata.last  = end_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			row_base_q <= '0;
		end else if (cfg.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (end_frame) begin
				col_q <= '0;
				row_q <= '0;
			end else if (end_line) begin
				col_q      <= '0;
				row_q      <= row_q + RW'(1);
				row_base_q <= base - AW'(pairs_c);
			end else begin
				col_q      <= col_q + CW'(1);
				row_base_q <= base;
			end
		end
	end

endmodule

// File: rtl/yrgb_queue.sv
// Short FIFO between the front end and the color back end.
// Depends on yrgb_pkg for the entry type and depth.
module yrgb_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  yrgb_pkg::pix_entry_t wdata,
	output logic                 full,
	input  logic                 pop,
	output logic                 valid,
	output yrgb_pkg::pix_entry_t rdata
);

	yrgb_pkg::pix_entry_t          mem [yrgb_pkg::Q_DEPTH];
	logic [yrgb_pkg::Q_PTR_W-1:0]  wr_ptr_q;
	logic [yrgb_pkg::Q_PTR_W-1:0]  rd_ptr_q;
	logic [yrgb_pkg::Q_CNT_W-1:0]  count_q;

	assign full  = count_q == yrgb_pkg::Q_CNT_W'(yrgb_pkg::Q_DEPTH);
	assign valid = count_q != '0;
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + yrgb_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + yrgb_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + yrgb_pkg::Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - yrgb_pkg::Q_CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/yrgb_back.sv
// Back end: two-stage color pipeline (chroma products, then sum, floor
// and clamp into the output register). Depends on yrgb_pkg.
module yrgb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  yrgb_pkg::pix_entry_t q_rdata,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output yrgb_pkg::rgb_t       out_data
);

	localparam int AW = yrgb_pkg::ADDR_W;
	localparam int FB = yrgb_pkg::FRAC_BITS;
	localparam int XW = yrgb_pkg::ACC_W;

	logic signed [yrgb_pkg::ACC_W-1:0] r_off_s1, g_off_s1, b_off_s1;
	logic [7:0]                        y0_s1, y1_s1;
	logic [AW-1:0]                     addr_s1;
	logic                              last_s1;
	logic                              valid_s1;
	logic                              valid_s2;
	logic                              adv1, adv2;
	logic signed [8:0]                 du, dv;
	logic signed [yrgb_pkg::ACC_W-1:0] du_x, dv_x;

	// floor by shift, then clamp to 0..255
	function automatic logic [7:0] chan(input logic [7:0] y,
		input logic signed [yrgb_pkg::ACC_W-1:0] off);
		logic signed [yrgb_pkg::ACC_W-1:0] acc;
		acc = $signed({3'b000, y, 14'd0}) + off;
		if (acc[yrgb_pkg::ACC_W-1]) begin
			return 8'd0;
		end else if (|acc[yrgb_pkg::ACC_W-2:FB+8]) begin
			return 8'd255;
		end else begin
			return acc[FB+7:FB];
		end
	endfunction

	assign adv2  = !valid_s2 || out_ready;
	assign adv1  = !valid_s1 || adv2;
	assign q_pop = q_valid && adv1;
	assign out_valid = valid_s2;

	assign du = $signed({1'b0, q_rdata.u}) - yrgb_pkg::CHROMA_OFS;
	assign dv = $signed({1'b0, q_rdata.v}) - yrgb_pkg::CHROMA_OFS;
	assign du_x = XW'(du);
	assign dv_x = XW'(dv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= q_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			r_off_s1 <= XW'(yrgb_pkg::COEF_RV) * dv_x;
			g_off_s1 <= -(XW'(yrgb_pkg::COEF_GU) * du_x) - XW'(yrgb_pkg::COEF_GV) * dv_x;
			b_off_s1 <= XW'(yrgb_pkg::COEF_BU) * du_x;
			y0_s1    <= q_rdata.y0;
			y1_s1    <= q_rdata.y1;
			addr_s1  <= q_rdata.addr;
			last_s1  <= q_rdata.last;
		end
		if (adv2 && valid_s1) begin
			out_data.b0   <= chan(y0_s1, b_off_s1);
			out_data.g0   <= chan(y0_s1, g_off_s1);
			out_data.r0   <= chan(y0_s1, r_off_s1);
			out_data.b1   <= chan(y1_s1, b_off_s1);
			out_data.g1   <= chan(y1_s1, g_off_s1);
			out_data.r1   <= chan(y1_s1, r_off_s1);
			out_data.addr <= addr_s1;
			out_data.last <= last_s1;
		end
	end

endmodule

// File: rtl/yrgb_checker.sv
// Port-level checks for the converter, bound to the top level.
// Depends on yuyv_to_rgb888_bottom_up and yrgb_pkg.
module yrgb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        pix_valid,
	input logic                        pix_ready,
	input logic                        rgb_valid,
	input logic                        rgb_ready,
	input logic [7:0]                  blue_first,
	input logic [7:0]                  green_first,
	input logic [7:0]                  red_first,
	input logic [7:0]                  blue_second,
	input logic [7:0]                  green_second,
	input logic [7:0]                  red_second,
	input logic [yrgb_pkg::ADDR_W-1:0] pair_address,
	input logic                        last_in_frame
);

	// a stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_ready |=> rgb_valid && $stable(pair_address) &&
			$stable(last_in_frame) && $stable(blue_first) && $stable(green_first) &&
			$stable(red_first) && $stable(blue_second) && $stable(green_second) &&
			$stable(red_second))
		else $error("stalled output transaction changed");

	// an accepted macropixel, or one ahead of it, is later in the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> ##2 rgb_valid)
		else $error("output not valid two cycles after input acceptance");

	// the queue cannot fill while the output register is empty
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rgb_valid |-> pix_ready)
		else $error("input stalled with empty output register");

endmodule

bind yuyv_to_rgb888_bottom_up yrgb_checker u_checker (.*);

// File: tb/tb_yuyv_to_rgb888_bottom_up.sv
// Self-checking testbench for the YUYV 4:2:2 to RGB888 converter, bottom-up addressing.
// Needs yrgb_pkg and yuyv_to_rgb888_bottom_up; a predictor checks every output transaction.
module tb_yuyv_to_rgb888_bottom_up;
	timeunit 1ns;
	timeprecision 1ps;

	// predictor constants: Q2.14 conversion coefficients and clamp limits
	localparam int Q_SHIFT    = 14;
	localparam int K_RED_V    = 22970;
	localparam int K_GREEN_U  = 5638;
	localparam int K_GREEN_V  = 11700;
	localparam int K_BLUE_U   = 29032;
	localparam int MAX_PAIRS  = 2048;
	localparam int MAX_LINES  = 4096;

	localparam int HOLD_CYCLES  = 200;	// long receiver hold-off
	localparam int SETTLE_CYCLES = 4;	// pipeline depth plus margin
	localparam int QUIET_LIMIT  = 5000;	// cycles with no transaction at all
	localparam int IDLE_PCT     = 83;	// idle share when one side alone idles
	localparam int BOTH_PCT     = 29;	// idle share when both sides idle

	typedef enum logic [2:0] {
		FLOW_FREE,
		FLOW_SRC_IDLE,
		FLOW_SNK_STALL,
		FLOW_BOTH,
		FLOW_HOLD
	} flow_t;

	typedef struct packed {
		logic [7:0] y0;
		logic [7:0] u;
		logic [7:0] y1;
		logic [7:0] v;
	} macropixel_t;

	typedef struct {
		macropixel_t    px;
		bit             typed;
		yrgb_pkg::rgb_t want;
	} directed_row_t;

	typedef struct {
		int    pairs;
		int    lines;
		int    count;
		flow_t flow;
	} frame_setup_t;

	// DUT ports; every input starts at a known value
	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          psel         = 1'b0;
	logic                          penable      = 1'b0;
	logic                          pwrite       = 1'b0;
	logic [2:0]                    paddr        = '0;
	logic [31:0]                   pwdata       = '0;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          pix_valid    = 1'b0;
	logic                          pix_ready;
	logic [7:0]                    luma_first   = '0;
	logic [7:0]                    chroma_blue  = '0;
	logic [7:0]                    luma_second  = '0;
	logic [7:0]                    chroma_red   = '0;
	logic                          rgb_valid;
	logic                          rgb_ready    = 1'b0;
	logic [7:0]                    blue_first;
	logic [7:0]                    green_first;
	logic [7:0]                    red_first;
	logic [7:0]                    blue_second;
	logic [7:0]                    green_second;
	logic [7:0]                    red_second;
	logic [yrgb_pkg::ADDR_W-1:0]   pair_address;
	logic                          last_in_frame;

	// predictor state: register contents and frame position
	logic [yrgb_pkg::LP_W-1:0]     pairs_reg  = yrgb_pkg::LINE_PAIRS_RST;
	logic [yrgb_pkg::FR_W-1:0]     lines_reg  = yrgb_pkg::FRAME_ROWS_RST;
	int                            column_pos = 0;
	int                            line_pos   = 0;
	logic [yrgb_pkg::ADDR_W-1:0]   line_base  = '0;

	yrgb_pkg::rgb_t      expected_pairs[$];
	int                  err_count     = 0;
	int                  src_idle_pct  = 0;
	int                  snk_stall_pct = 0;
	int                  hold_requests = 0;
	int                  hold_served   = 0;
	int                  quiet_cycles  = 0;

	yuyv_to_rgb888_bottom_up DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pix_valid    (pix_valid),
		.pix_ready    (pix_ready),
		.luma_first   (luma_first),
		.chroma_blue  (chroma_blue),
		.luma_second  (luma_second),
		.chroma_red   (chroma_red),
		.rgb_valid    (rgb_valid),
		.rgb_ready    (rgb_ready),
		.blue_first   (blue_first),
		.green_first  (green_first),
		.red_first    (red_first),
		.blue_second  (blue_second),
		.green_second (green_second),
		.red_second   (red_second),
		.pair_address (pair_address),
		.last_in_frame(last_in_frame)
	);

	always #5 clk = ~clk;

	// One channel: luma scaled to Q.14 plus the chroma term, floored by the
	// arithmetic shift, then clamped to 0..255.
	function automatic logic [7:0] sat_channel(logic [7:0] luma, int chroma_term);
		int acc;
		int level;
		acc = int'(luma) * (1 << Q_SHIFT) + chroma_term;
		level = acc >>> Q_SHIFT;
		if (level < 0)
			level = 0;
		if (level > 255)
			level = 255;
		return 8'(level);
	endfunction

	// Convert one macropixel and advance the frame position, the way the block
	// walks a frame: row base loaded on the first pair, lowered at each line end.
	function automatic yrgb_pkg::rgb_t predict_pair(macropixel_t px);
		int             pairs;
		int             lines;
		int             du;
		int             dv;
		int             red_term;
		int             green_term;
		int             blue_term;
		bit             line_end;
		bit             frame_end;
		yrgb_pkg::rgb_t res;
		// out-of-range register values are clamped when used; zero acts as one
		pairs = (pairs_reg == 0) ? 1 :
			(int'(pairs_reg) > MAX_PAIRS) ? MAX_PAIRS : int'(pairs_reg);
		lines = (lines_reg == 0) ? 1 :
			(int'(lines_reg) > MAX_LINES) ? MAX_LINES : int'(lines_reg);
		if (column_pos == 0 && line_pos == 0)
			line_base = yrgb_pkg::ADDR_W'((lines - 1) * pairs);
		du = int'(px.u) - 128;
		dv = int'(px.v) - 128;
		red_term   = K_RED_V * dv;
		green_term = -(K_GREEN_U * du) - K_GREEN_V * dv;
		blue_term  = K_BLUE_U * du;
		res.b0   = sat_channel(px.y0, blue_term);
		res.g0   = sat_channel(px.y0, green_term);
		res.r0   = sat_channel(px.y0, red_term);
		res.b1   = sat_channel(px.y1, blue_term);
		res.g1   = sat_channel(px.y1, green_term);
		res.r1   = sat_channel(px.y1, red_term);
		res.addr = line_base + yrgb_pkg::ADDR_W'(column_pos);
		line_end  = (column_pos + 1 >= pairs);
		frame_end = line_end && (line_pos + 1 >= lines);
		res.last  = frame_end;
		if (frame_end) begin
			column_pos = 0;
			line_pos   = 0;
		end else if (line_end) begin
			column_pos = 0;
			line_pos   = line_pos + 1;
			line_base  = line_base - yrgb_pkg::ADDR_W'(pairs);
		end else begin
			column_pos = column_pos + 1;
		end
		return res;
	endfunction

	// Random sample with the extremes weighted up so clamping is hit often.
	function automatic logic [7:0] random_sample();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 8'd0;
		if (pick == 1)
			return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	// APB write: setup cycle, access cycle, then psel is driven low before the task
	// returns, so that back-to-back transfers never assign psel twice in one time step.
	task automatic apb_write(yrgb_pkg::reg_idx_t idx, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		// any write restarts the frame at the top line
		if (idx == yrgb_pkg::REG_LINE_PAIRS)
			pairs_reg = data[yrgb_pkg::LP_W-1:0];
		else
			lines_reg = data[yrgb_pkg::FR_W-1:0];
		column_pos = 0;
		line_pos   = 0;
	endtask

	// APB read; prdata is sampled at the edge that completes the access.
	task automatic apb_check(yrgb_pkg::reg_idx_t idx, logic [31:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$display("%0t register %s readback: expected %0d, actual %0d",
				$time, idx.name(), want, prdata);
			err_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one macropixel and hold it until it is taken. The predictor runs at
	// the accepting edge; the block's result comes out later, through the queue and back end.
	// A typed row replaces the prediction with the hand-written value.
	task automatic send_pixel(macropixel_t px, bit typed, yrgb_pkg::rgb_t want);
		yrgb_pkg::rgb_t predicted;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid   <= 1'b1;
		luma_first  <= px.y0;
		chroma_blue <= px.u;
		luma_second <= px.y1;
		chroma_red  <= px.v;
		forever begin
			@(posedge clk);
			if (pix_valid && pix_ready)
				break;
		end
		predicted = predict_pair(px);
		expected_pairs.push_back(typed ? want : predicted);
	endtask

	// Wait until every expected transaction has arrived, then let the pipeline
	// settle before anything is reconfigured or the run ends.
	task automatic drain_pipeline();
		pix_valid <= 1'b0;
		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(string field, int want, int got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
			err_count++;
		end
	endtask

	// Output monitor: every accepted transaction is compared with the oldest
	// expectation; one with nothing waiting is an error on its own.
	always @(posedge clk) begin
		yrgb_pkg::rgb_t want;
		if (arst_n && rgb_valid && rgb_ready) begin
			if (expected_pairs.size() == 0) begin
				$display("%0t unexpected pair: actual addr %0d last %0d",
					$time, pair_address, last_in_frame);
				err_count++;
			end else begin
				want = expected_pairs.pop_front();
				check_field("blue_first",    want.b0,   blue_first);
				check_field("green_first",   want.g0,   green_first);
				check_field("red_first",     want.r0,   red_first);
				check_field("blue_second",   want.b1,   blue_second);
				check_field("green_second",  want.g1,   green_second);
				check_field("red_second",    want.r1,   red_second);
				check_field("pair_address",  want.addr, pair_address);
				check_field("last_in_frame", want.last, last_in_frame);
			end
		end
	end

	// Receiver: a requested hold-off drops ready for a counted stretch while the
	// sender keeps offering, so the queue fills and pix_ready falls; otherwise
	// stall for the requested share of cycles, else stay ready.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served++;
				rgb_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rgb_ready <= 1'b1;
			end else if (arst_n) begin
				rgb_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
			end
		end
	end

	// Watchdog: end the run when no transaction of any kind moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_valid && pix_ready) || (rgb_valid && rgb_ready) || psel)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("[yuyv_to_rgb888_bottom_up] ERROR");
				$finish;
			end
		end
	end

	initial begin
		directed_row_t  directed[$];
		frame_setup_t   setups[$];
		frame_setup_t   cur;
		macropixel_t    px;

		// Directed rows run at the reset setting, 320 pairs by 480 lines, so the
		// first pair lands at (480-1)*320 = 153280. The first four are typed:
		// black, white, and both chroma extremes, where clamping shows.
		directed = '{
			'{'{8'd0,   8'd128, 8'd0,   8'd128}, 1'b1,
				'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 23'd153280, 1'b0}},
			'{'{8'd255, 8'd128, 8'd255, 8'd128}, 1'b1,
				'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 23'd153281, 1'b0}},
			'{'{8'd0,   8'd0,   8'd255, 8'd0},   1'b1,
				'{8'd0, 8'd135, 8'd0, 8'd28, 8'd255, 8'd75, 23'd153282, 1'b0}},
			'{'{8'd0,   8'd255, 8'd255, 8'd255}, 1'b1,
				'{8'd225, 8'd0, 8'd178, 8'd255, 8'd120, 8'd255, 23'd153283, 1'b0}},
			'{'{8'd255, 8'd0,   8'd0,   8'd255}, 1'b0, '0},
			'{'{8'd0,   8'd255, 8'd255, 8'd0},   1'b0, '0},
			'{'{8'd128, 8'd128, 8'd128, 8'd128}, 1'b0, '0},
			'{'{8'd128, 8'd0,   8'd128, 8'd255}, 1'b0, '0},
			'{'{8'd16,  8'd128, 8'd235, 8'd128}, 1'b0, '0},
			'{'{8'd255, 8'd255, 8'd0,   8'd0},   1'b0, '0},
			'{'{8'd1,   8'd127, 8'd254, 8'd129}, 1'b0, '0},
			'{'{8'd170, 8'd85,  8'd85,  8'd170}, 1'b0, '0},
			'{'{8'd85,  8'd170, 8'd170, 8'd85},  1'b0, '0},
			'{'{8'd235, 8'd240, 8'd16,  8'd16},  1'b0, '0}
		};

		// Frame settings for the random part: tiny frames that wrap often, the
		// single-pair frame, zero and oversized values that must clamp, the
		// largest frame for high addresses, and one phase with a long hold-off.
		setups = '{
			'{3,    2,    150, FLOW_FREE},
			'{1,    1,    100, FLOW_SRC_IDLE},
			'{0,    5,    100, FLOW_SNK_STALL},
			'{5,    0,    100, FLOW_BOTH},
			'{2048, 4096, 120, FLOW_FREE},
			'{4095, 8191, 80,  FLOW_SNK_STALL},
			'{7,    3,    150, FLOW_HOLD},
			'{17,   4,    100, FLOW_BOTH},
			'{4,    9,    150, FLOW_SRC_IDLE}
		};

		// hold reset, then release it once
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_check(yrgb_pkg::REG_LINE_PAIRS, 32'(yrgb_pkg::LINE_PAIRS_RST));
		apb_check(yrgb_pkg::REG_FRAME_ROWS, 32'(yrgb_pkg::FRAME_ROWS_RST));

		foreach (directed[i])
			send_pixel(directed[i].px, directed[i].typed, directed[i].want);
		drain_pipeline();

		foreach (setups[p]) begin
			cur = setups[p];
			// reconfigure only once the block is empty; each write restarts the frame
			apb_write(yrgb_pkg::REG_LINE_PAIRS, 32'(cur.pairs));
			apb_check(yrgb_pkg::REG_LINE_PAIRS, 32'(cur.pairs) & 32'hFFF);
			apb_write(yrgb_pkg::REG_FRAME_ROWS, 32'(cur.lines));
			apb_check(yrgb_pkg::REG_FRAME_ROWS, 32'(cur.lines) & 32'h1FFF);

			src_idle_pct  = 0;
			snk_stall_pct = 0;
			case (cur.flow)
				FLOW_SRC_IDLE:  src_idle_pct = IDLE_PCT;
				FLOW_SNK_STALL: snk_stall_pct = IDLE_PCT;
				FLOW_BOTH: begin
					src_idle_pct  = BOTH_PCT;
					snk_stall_pct = BOTH_PCT;
				end
				FLOW_HOLD:      hold_requests++;
				default: ;
			endcase

			for (int n = 0; n < cur.count; n++) begin
				px.y0 = random_sample();
				px.u  = random_sample();
				px.y1 = random_sample();
				px.v  = random_sample();
				send_pixel(px, 1'b0, '0);
			end
			drain_pipeline();
			src_idle_pct  = 0;
			snk_stall_pct = 0;
		end

		if (err_count == 0)
			$display("[yuyv_to_rgb888_bottom_up] OK");
		else
			$display("[yuyv_to_rgb888_bottom_up] ERROR");
		$finish;
	end

endmodule
